### rtl/csm_pkg.sv
// csm_pkg: shared widths, the column record and queue status types and the
// divider state codes for the column sum and mean unit. Depends on nothing.
`timescale 1ns / 1ps

package csm_pkg;

    // field widths
    localparam int C_VALUE_W   = 32;
    localparam int C_SUM_W     = 48;
    localparam int C_CNT_W     = 17;
    localparam int C_FRAC_W    = 16;

    // default row limit per column
    localparam int C_MAX_ROWS  = 65536;

    // missing marker, the most negative 32-bit value
    localparam logic [C_VALUE_W-1:0] C_MISSING_CODE = {1'b1, {(C_VALUE_W-1){1'b0}}};

    // column queue between the accumulator and the divider
    localparam int C_QUEUE_DEPTH = 2;
    localparam int C_QPTR_W      = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int C_QCNT_W      = $clog2(C_QUEUE_DEPTH + 1);

    // divider: dividend is |sum| shifted up by the fraction bits
    localparam int C_DIVD_W = C_SUM_W + C_FRAC_W;
    localparam int C_STEP_W = $clog2(C_DIVD_W);

    // one closed column, as handed from the front to the divider
    typedef struct packed {
        logic signed [C_SUM_W-1:0] sum;
        logic [C_CNT_W-1:0]        count;
        logic                      missing;
        logic                      empty;
    } t_col_rec;

    // queue handshake toward the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage

### rtl/column_sum_mean_with_missing_unit.sv
// column_sum_mean_with_missing_unit: top level of the column sum and mean
// unit; holds the mode register. Depends on csm_pkg, csm_front, csm_queue, csm_back.
`timescale 1ns / 1ps

// Use:
//   Input channel (i_valid/o_ready) carries one column-major matrix element a
//   cycle with a last-row mark. The value -2147483648 marks a missing element.
//   Output channel (o_valid/i_ready) carries one result per column: sum, mean
//   in signed fixed point with 16 fraction bits, used count, missing and
//   empty flags. The config channel (i_cfg_valid/o_cfg_ready) writes
//   skip_missing; write it only while no column is in flight.
// Throughput: elements enter one per cycle while the column queue has room.
//   Each column end costs the divider a pop, 64 one-bit restoring steps and
//   the hand-off to the output register; a missing or empty column skips
//   the steps. The divider works on one column at a time; a two-entry
//   column queue lets short columns arrive in bursts.
// Result path: a closed column's record passes through the queue and the
//   divider into the output register, which raises o_valid when the divider
//   and the output register are free.
// Reset: synchronous, active low; clears the column state, the queue and the
//   output valid and sets skip_missing to 1.
// Stall: a stalled receiver holds the result in the output register; the
//   divider and then the queue fill, after which o_ready drops.
module column_sum_mean_with_missing_unit #(
    parameter int MAX_ROWS = csm_pkg::C_MAX_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_skip_missing,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [csm_pkg::C_VALUE_W-1:0] i_value,
    input  logic                                i_last_in_column,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [csm_pkg::C_SUM_W-1:0]  o_column_sum,
    output logic signed [csm_pkg::C_SUM_W-1:0]  o_column_mean,
    output logic [csm_pkg::C_CNT_W-1:0]         o_used_count,
    output logic                                o_result_missing,
    output logic                                o_result_empty
);
    import csm_pkg::*;

    logic      r_skip_missing;
    logic      push;
    logic      pop;
    t_col_rec  push_rec;
    t_col_rec  head_rec;
    t_q_status q_status;

    // mode register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_missing <= 1'b1;
        end else if (i_cfg_valid) begin
            r_skip_missing <= i_skip_missing;
        end
    end

    // accumulator
    csm_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_value          (i_value),
        .i_last_in_column (i_last_in_column),
        .i_skip_missing   (r_skip_missing),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_rec            (push_rec)
    );

    // column record queue
    csm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_rec    (head_rec),
        .o_status (q_status)
    );

    // divider and output register
    csm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_status       (q_status),
        .i_rec            (head_rec),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_column_sum     (o_column_sum),
        .o_column_mean    (o_column_mean),
        .o_used_count     (o_used_count),
        .o_result_missing (o_result_missing),
        .o_result_empty   (o_result_empty)
    );

endmodule

### rtl/csm_front.sv
// csm_front: takes elements, keeps the running column sum and counts, and
// emits one column record on the last element. Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_front #(
    parameter int MAX_ROWS = csm_pkg::C_MAX_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [csm_pkg::C_VALUE_W-1:0] i_value,
    input  logic                                i_last_in_column,
    input  logic                                i_skip_missing,
    input  csm_pkg::t_q_status                  i_q_status,
    output logic                                o_push,
    output csm_pkg::t_col_rec                   o_rec
);
    import csm_pkg::*;

    logic signed [C_SUM_W-1:0] r_sum, n_sum;
    logic [C_CNT_W-1:0]        r_used, n_used;
    logic [C_CNT_W-1:0]        r_rows, n_rows;
    logic                      r_miss, n_miss;

    logic                      accept;
    logic                      taken;
    logic                      is_miss;
    logic                      use_value;
    logic                      rec_missing;
    logic                      rec_empty;
    logic signed [C_SUM_W-1:0] value_ext;

    // a request is taken whenever the queue has room
    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && i_last_in_column;

    // classify the element
    assign taken     = r_rows < C_CNT_W'(MAX_ROWS);
    assign is_miss   = i_value == C_MISSING_CODE;
    assign use_value = taken && !is_miss && (i_skip_missing || !r_miss);
    assign value_ext = {{(C_SUM_W-C_VALUE_W){i_value[C_VALUE_W-1]}}, i_value};

    // column state including this element
    always_comb begin
        n_rows = r_rows + C_CNT_W'(taken);
        n_miss = r_miss || (taken && is_miss);
        n_used = r_used + C_CNT_W'(use_value);
        n_sum  = use_value ? r_sum + value_ext : r_sum;
    end

    // closed column record, special cases carry zeros
    always_comb begin
        rec_missing   = !i_skip_missing && n_miss;
        rec_empty     = !rec_missing && (n_used == '0);
        o_rec.missing = rec_missing;
        o_rec.empty   = rec_empty;
        o_rec.sum     = (rec_missing || rec_empty) ? '0 : n_sum;
        o_rec.count   = (rec_missing || rec_empty) ? '0 : n_used;
    end

    // running column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_used <= '0;
            r_rows <= '0;
            r_miss <= 1'b0;
        end else if (accept) begin
            if (i_last_in_column) begin
                r_sum  <= '0;
                r_used <= '0;
                r_rows <= '0;
                r_miss <= 1'b0;
            end else begin
                r_sum  <= n_sum;
                r_used <= n_used;
                r_rows <= n_rows;
                r_miss <= n_miss;
            end
        end
    end

    // used values never outnumber the rows counted, rows stop at the limit
    a_used_le_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_rows)
        else $error("used count above row count");
    a_rows_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= C_CNT_W'(MAX_ROWS))
        else $error("row count beyond limit");

endmodule

### rtl/csm_queue.sv
// csm_queue: short register queue of closed column records between the
// accumulator and the divider. Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  csm_pkg::t_col_rec  i_rec,
    input  logic               i_pop,
    output csm_pkg::t_col_rec  o_rec,
    output csm_pkg::t_q_status o_status
);
    import csm_pkg::*;

    t_col_rec              r_mem [C_QUEUE_DEPTH];
    logic [C_QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [C_QCNT_W-1:0]   r_count;

    assign o_status.full  = r_count == C_QCNT_W'(C_QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_rec          = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == C_QPTR_W'(C_QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == C_QPTR_W'(C_QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

endmodule

### rtl/csm_back.sv
// csm_back: pops column records, forms the fixed point mean with a bit-serial
// restoring divider and holds the result in the output register. Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csm_pkg::t_q_status                  i_q_status,
    input  csm_pkg::t_col_rec                   i_rec,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [csm_pkg::C_SUM_W-1:0]  o_column_sum,
    output logic signed [csm_pkg::C_SUM_W-1:0]  o_column_mean,
    output logic [csm_pkg::C_CNT_W-1:0]         o_used_count,
    output logic                                o_result_missing,
    output logic                                o_result_empty
);
    import csm_pkg::*;

    t_back_state               r_state, n_state;

    // record being worked on
    logic signed [C_SUM_W-1:0] r_sum;
    logic [C_CNT_W-1:0]        r_div;
    logic                      r_missing;
    logic                      r_empty;
    logic                      r_neg;

    // divider: dividend shifts out at the top, quotient shifts in below
    logic [C_DIVD_W-1:0]       r_dq;
    logic [C_CNT_W-1:0]        r_rem;
    logic [C_STEP_W-1:0]       r_step;

    // output register
    logic                      r_out_valid;
    logic signed [C_SUM_W-1:0] r_out_sum;
    logic signed [C_SUM_W-1:0] r_out_mean;
    logic [C_CNT_W-1:0]        r_out_cnt;
    logic                      r_out_missing;
    logic                      r_out_empty;

    logic                      load;
    logic                      start_div;
    logic                      last_step;
    logic [C_CNT_W:0]          rem_sh;
    logic                      q_bit;
    logic [C_CNT_W:0]          rem_diff;
    logic [C_SUM_W-1:0]        mag;
    logic [C_SUM_W-1:0]        quot;
    logic signed [C_SUM_W-1:0] mean;

    // one restoring step
    always_comb begin
        rem_sh   = {r_rem, r_dq[C_DIVD_W-1]};
        q_bit    = rem_sh >= {1'b0, r_div};
        rem_diff = rem_sh - {1'b0, r_div};
    end

    assign last_step = r_step == C_STEP_W'(C_DIVD_W-1);
    assign start_div = !i_rec.missing && !i_rec.empty;
    assign mag       = i_rec.sum[C_SUM_W-1] ? C_SUM_W'(-i_rec.sum) : C_SUM_W'(i_rec.sum);
    assign quot      = r_dq[C_SUM_W-1:0];
    assign mean      = r_neg ? -$signed(quot) : $signed(quot);

    // next state and handshakes
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = start_div ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // record capture and division datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sum     <= i_rec.sum;
            r_div     <= i_rec.count;
            r_missing <= i_rec.missing;
            r_empty   <= i_rec.empty;
            r_neg     <= i_rec.sum[C_SUM_W-1];
            r_dq      <= start_div ? {mag, {C_FRAC_W{1'b0}}} : '0;
            r_rem     <= '0;
            r_step    <= '0;
        end else if (r_state == S_DIV) begin
            r_dq   <= {r_dq[C_DIVD_W-2:0], q_bit};
            r_rem  <= q_bit ? rem_diff[C_CNT_W-1:0] : rem_sh[C_CNT_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    // output register, filled when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_sum     <= r_sum;
            r_out_mean    <= mean;
            r_out_cnt     <= r_div;
            r_out_missing <= r_missing;
            r_out_empty   <= r_empty;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_column_sum     = r_out_sum;
    assign o_column_mean    = r_out_mean;
    assign o_used_count     = r_out_cnt;
    assign o_result_missing = r_out_missing;
    assign o_result_empty   = r_out_empty;

    // a division always runs against a nonzero count
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("division by zero count");
    // special results carry zeros
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_missing || o_result_empty)) |->
        (o_column_sum == '0 && o_column_mean == '0 && o_used_count == '0))
        else $error("special result with nonzero payload");

endmodule

### tb/sv/testbench.sv
// testbench: self-checking bench for the column sum and mean unit, with a
// column predictor in a small scoreboard class. Depends on csm_pkg and the unit.
`timescale 1ns / 1ps

// one column result as seen on the output ports
typedef struct packed {
    logic signed [csm_pkg::C_SUM_W-1:0] sum;
    logic signed [csm_pkg::C_SUM_W-1:0] mean;
    logic [csm_pkg::C_CNT_W-1:0]        count;
    logic                               missing;
    logic                               empty;
} column_result_t;

// predicts column results from accepted requests and checks the output
class column_tracker;
    bit                 skip_mode;
    longint             acc_sum;
    int unsigned        used_n;
    int unsigned        rows_n;
    bit                 miss_flag;
    column_result_t     expected_columns[$];
    int unsigned        mismatches;
    int unsigned        columns_checked;

    function new();
        skip_mode = 1'b1;
        mismatches = 0;
        columns_checked = 0;
        clear_column();
    endfunction

    function void clear_column();
        acc_sum = 0;
        used_n = 0;
        rows_n = 0;
        miss_flag = 1'b0;
    endfunction

    function void set_mode(bit m);
        skip_mode = m;
    endfunction

    function int pending();
        return expected_columns.size();
    endfunction

    // signed fixed point mean, 16 fraction bits, truncated toward zero
    function logic [csm_pkg::C_SUM_W-1:0] fixed_mean(longint s, longint unsigned n);
        longint unsigned mag;
        longint unsigned q;
        if (n == 0)
            return '0;
        mag = (s < 0) ? longint'(-s) : s;
        q = (mag << csm_pkg::C_FRAC_W) / n;
        if (s < 0)
            q = -q;
        return q[csm_pkg::C_SUM_W-1:0];
    endfunction

    // take in one accepted element, queue a result when it closes the column
    function void take_element(logic [csm_pkg::C_VALUE_W-1:0] raw, logic last);
        column_result_t r;
        bit is_miss;
        is_miss = (raw == csm_pkg::C_MISSING_CODE);
        // elements past the row limit are dropped entirely
        if (rows_n < csm_pkg::C_MAX_ROWS) begin
            rows_n++;
            if (is_miss) begin
                miss_flag = 1'b1;
            end else if (skip_mode || !miss_flag) begin
                acc_sum += longint'(signed'(raw));
                used_n++;
            end
        end
        if (!last)
            return;
        r = '0;
        if (skip_mode) begin
            if (used_n == 0) begin
                r.empty = 1'b1;
            end else begin
                r.sum = acc_sum[csm_pkg::C_SUM_W-1:0];
                r.mean = fixed_mean(acc_sum, used_n);
                r.count = used_n[csm_pkg::C_CNT_W-1:0];
            end
        end else if (miss_flag) begin
            r.missing = 1'b1;
        end else if (rows_n == 0 || used_n == 0) begin
            r.empty = 1'b1;
        end else begin
            r.sum = acc_sum[csm_pkg::C_SUM_W-1:0];
            r.mean = fixed_mean(acc_sum, rows_n);
            r.count = used_n[csm_pkg::C_CNT_W-1:0];
        end
        expected_columns.push_back(r);
        clear_column();
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_column(column_result_t got);
        column_result_t want;
        bit bad;
        if (expected_columns.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected column result: sum %0d mean %0d count %0d miss %0b empty %0b",
                         got.sum, got.mean, got.count, got.missing, got.empty);
            return;
        end
        want = expected_columns.pop_front();
        bad = (got.sum !== want.sum) || (got.mean !== want.mean) ||
              (got.count !== want.count) || (got.missing !== want.missing) ||
              (got.empty !== want.empty);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("column %0d mismatch at %0t", columns_checked, $realtime);
                $display("  expected: sum %0d mean %0d count %0d miss %0b empty %0b",
                         want.sum, want.mean, want.count, want.missing, want.empty);
                $display("  actual:   sum %0d mean %0d count %0d miss %0b empty %0b",
                         got.sum, got.mean, got.count, got.missing, got.empty);
            end
        end
        columns_checked++;
    endfunction
endclass

module testbench;

    localparam bit MODE_PROPAGATE = 1'b0;
    localparam bit MODE_SKIP      = 1'b1;
    localparam logic [csm_pkg::C_VALUE_W-1:0] MISSING = csm_pkg::C_MISSING_CODE;
    localparam int SETTLE_CYCLES  = 100;
    localparam int DRAIN_LIMIT    = 50000;
    localparam int CHUNKS         = 3;
    localparam int CHUNK_ITEMS    = 80;
    localparam int LONG_COLUMN    = 48;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic                                i_skip_missing = 1'b1;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic signed [csm_pkg::C_VALUE_W-1:0] i_value = '0;
    logic                                i_last_in_column = 1'b0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic signed [csm_pkg::C_SUM_W-1:0]  o_column_sum;
    logic signed [csm_pkg::C_SUM_W-1:0]  o_column_mean;
    logic [csm_pkg::C_CNT_W-1:0]         o_used_count;
    logic                                o_result_missing;
    logic                                o_result_empty;

    column_tracker  tracker;
    column_result_t observed;
    int             send_idle_pct = 6;
    int             recv_idle_pct = 81;

    column_sum_mean_with_missing_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_skip_missing   (i_skip_missing),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_value          (i_value),
        .i_last_in_column (i_last_in_column),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_column_sum     (o_column_sum),
        .o_column_mean    (o_column_mean),
        .o_used_count     (o_used_count),
        .o_result_missing (o_result_missing),
        .o_result_empty   (o_result_empty)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: check accepted results, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            observed.sum = o_column_sum;
            observed.mean = o_column_mean;
            observed.count = o_used_count;
            observed.missing = o_result_missing;
            observed.empty = o_result_empty;
            tracker.check_column(observed);
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one element request, with a random gap before it
    task automatic send_element(input logic [csm_pkg::C_VALUE_W-1:0] v, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last_in_column <= last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        tracker.take_element(v, last);
    endtask

    // stop sending, wait for all predicted results and the pipeline tail
    task automatic settle();
        int n;
        i_valid <= 1'b0;
        n = 0;
        while (tracker.pending() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mode register write request
    task automatic write_mode(input bit m);
        i_cfg_valid <= 1'b1;
        i_skip_missing <= m;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        tracker.set_mode(m);
        i_cfg_valid <= 1'b0;
    endtask

    // element value mix: missing, corners, small values, full range
    function automatic logic [csm_pkg::C_VALUE_W-1:0] pick_value(input int miss_pct);
        int r;
        if ($urandom_range(99) < miss_pct)
            return MISSING;
        r = $urandom_range(99);
        if (r < 8) begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0001;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 40)
            return $urandom_range(2000) - 1000;
        return $urandom();
    endfunction

    // whole column with random length and missing density
    task automatic send_random_column(output int len);
        int r;
        int miss_pct;
        r = $urandom_range(99);
        if (r < 70)
            len = $urandom_range(6, 1);
        else if (r < 95)
            len = $urandom_range(24, 7);
        else
            len = $urandom_range(120, 25);
        case ($urandom_range(5))
            0, 1, 2: miss_pct = 0;
            3: miss_pct = 8;
            4: miss_pct = 40;
            default: miss_pct = 100;
        endcase
        for (int k = 0; k < len; k++)
            send_element(pick_value(miss_pct), k == len - 1);
    endtask

    // random columns in chunks, each after a drain and a mode write
    task automatic run_random_phase(input int snd_pct, input int rcv_pct);
        int chunk_items;
        int len;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (CHUNKS) begin
            settle();
            write_mode(1'($urandom_range(1)));
            chunk_items = 0;
            while (chunk_items < CHUNK_ITEMS) begin
                send_random_column(len);
                chunk_items += len;
            end
        end
    endtask

    // run limit
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // main sequence
    initial begin
        tracker = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed, skip mode from reset: extremes, lone missing, truncation
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h8000_0001, 1'b0);
        send_element(1, 1'b1);
        send_element(MISSING, 1'b1);
        send_element(-7, 1'b0);
        send_element(MISSING, 1'b0);
        send_element(2, 1'b1);
        send_element(-1, 1'b0);
        send_element(0, 1'b0);
        send_element(0, 1'b1);

        // missing seen in skip mode, column closed in propagate mode
        send_element(10, 1'b0);
        send_element(MISSING, 1'b0);
        send_element(20, 1'b0);
        settle();
        write_mode(MODE_PROPAGATE);
        send_element(30, 1'b1);

        // propagate mode: clean column, missing in the middle, extremes
        send_element(3, 1'b0);
        send_element(4, 1'b0);
        send_element(5, 1'b1);
        send_element(1, 1'b0);
        send_element(MISSING, 1'b0);
        send_element(9, 1'b1);
        send_element(32'h8000_0001, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(-3, 1'b1);

        // back to skip mode inside a column
        send_element(6, 1'b0);
        send_element(7, 1'b0);
        settle();
        write_mode(MODE_SKIP);
        send_element(MISSING, 1'b0);
        send_element(8, 1'b1);

        // random phases with changing idle patterns
        run_random_phase(6, 81);
        run_random_phase(81, 6);
        run_random_phase(0, 0);

        // long column of largest values with a missing one near the end
        settle();
        write_mode(MODE_SKIP);
        for (int k = 0; k < LONG_COLUMN; k++)
            send_element(32'h7FFF_FFFF, 1'b0);
        send_element(MISSING, 1'b0);
        send_element(-5, 1'b0);
        send_element(123, 1'b1);

        // long column of the most negative non-missing value in propagate mode
        settle();
        write_mode(MODE_PROPAGATE);
        for (int k = 0; k < LONG_COLUMN; k++)
            send_element(32'h8000_0001, k == LONG_COLUMN - 1);

        settle();
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/csm_pkg.sv
rtl/csm_front.sv
rtl/csm_queue.sv
rtl/csm_back.sv
rtl/column_sum_mean_with_missing_unit.sv
tb/sv/testbench.sv
